// ===== src/sdt_pkg.sv =====
// shared types for the seen device table
package sdt_pkg;

  typedef struct packed {
    logic [47:0]        device_address;
    logic signed [7:0]  signal_strength;
    logic [31:0]        now_seconds;
  } sdt_in_t;

  typedef struct packed {
    logic               was_hit;
    logic               was_evicted;
    logic [6:0]         entry_slot;
    logic [15:0]        sighting_count;
    logic signed [7:0]  peak_strength;
    logic [31:0]        first_seen_time;
    logic [7:0]         entries_used;
  } sdt_out_t;

  typedef struct packed {
    logic [47:0]        key;
    logic [31:0]        created_at;
    logic [15:0]        count;
    logic signed [7:0]  peak;
  } sdt_entry_t;

endpackage

// ===== src/sdt_cell.sv =====
// one table entry: storage plus a link in the rotating scan ring
module sdt_cell (
  input  logic              clk,
  input  logic              shift,
  input  sdt_pkg::sdt_entry_t prev_entry,
  output sdt_pkg::sdt_entry_t entry
);
  import sdt_pkg::*;

  sdt_entry_t entry_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= prev_entry;
    end
  end

  assign entry = entry_r;
endmodule

// ===== src/seen_device_table.sv =====
// seen device table: ring of entry cells rotated past one compare/update head
// from input accept to result: one full rotation of the cell ring to search (one
// entry compared per cycle), the S_PICK state to pick the target entry, then a
// second rotation that writes the updated entry back
// next sighting waits for write-back; input stalls while busy or a result is stalled
// reset clears the fill count and control; entry contents are undefined until written
module seen_device_table #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdt_pkg::sdt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sdt_pkg::sdt_out_t out_data
);
  import sdt_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PICK, S_WRITE} state_t;

  state_t        state_r;
  sdt_in_t       req_r;
  logic [CW-1:0] used_r;
  logic [CW-1:0] pos_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [IW-1:0] old_idx_r;
  logic [31:0]   old_time_r;
  logic          out_valid_r;
  sdt_out_t      out_r;
  logic [CW-1:0] tgt_r;
  logic          evict_r;

  sdt_entry_t    cells [TABLE_ENTRIES];
  sdt_entry_t    head_in;
  logic          shift;
  logic [IW-1:0] pos_idx;
  logic          in_range;
  logic          tgt_match;
  sdt_entry_t    upd;

  // ring: cell k takes from cell k+1, the last cell takes the head input
  // cells[0] is the entry with index pos_r during both rotations
  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      if (g == TABLE_ENTRIES - 1) begin : g_last
        sdt_cell u_cell (.clk(clk), .shift(shift), .prev_entry(head_in),
                         .entry(cells[g]));
      end else begin : g_mid
        sdt_cell u_cell (.clk(clk), .shift(shift), .prev_entry(cells[g+1]),
                         .entry(cells[g]));
      end
    end
  endgenerate

  assign pos_idx  = pos_r[IW-1:0];
  assign in_range = pos_r < used_r;
  assign shift    = (state_r == S_SCAN) || (state_r == S_WRITE);
  assign tgt_match = pos_r == tgt_r;

  // modified copy of the target entry
  always_comb begin
    upd = cells[0];
    if (hit_r) begin
      upd.count = cells[0].count + 16'd1;
      if (req_r.signal_strength > cells[0].peak) begin
        upd.peak = req_r.signal_strength;
      end
    end else begin
      upd.key        = req_r.device_address;
      upd.created_at = req_r.now_seconds;
      upd.count      = 16'd1;
      upd.peak       = req_r.signal_strength;
    end
  end

  always_comb begin
    head_in = cells[0];
    if (state_r == S_WRITE && tgt_match) begin
      head_in = upd;
    end
  end

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_r      <= in_data;
            pos_r      <= '0;
            hit_r      <= 1'b0;
            hit_idx_r  <= '0;
            old_idx_r  <= '0;
            old_time_r <= '1;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (in_range && !hit_r && cells[0].key == req_r.device_address) begin
            hit_r     <= 1'b1;
            hit_idx_r <= pos_idx;
          end
          if (pos_r == '0 || cells[0].created_at < old_time_r) begin
            old_idx_r  <= pos_idx;
            old_time_r <= cells[0].created_at;
          end
          if (pos_r == CW'(TABLE_ENTRIES - 1)) begin
            pos_r   <= '0;
            state_r <= S_PICK;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        S_PICK: begin
          if (hit_r) begin
            tgt_r   <= CW'(hit_idx_r);
            evict_r <= 1'b0;
          end else if (used_r < CW'(TABLE_ENTRIES)) begin
            tgt_r   <= used_r;
            used_r  <= used_r + 1'b1;
            evict_r <= 1'b0;
          end else begin
            tgt_r   <= CW'(old_idx_r);
            evict_r <= 1'b1;
          end
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          // second rotation writes the updated entry at the target position
          if (tgt_match) begin
            out_r.was_hit         <= hit_r;
            out_r.was_evicted     <= evict_r;
            out_r.entry_slot      <= 7'(tgt_r);
            out_r.sighting_count  <= upd.count;
            out_r.peak_strength   <= upd.peak;
            out_r.first_seen_time <= upd.created_at;
            out_r.entries_used    <= 8'(used_r);
          end
          if (pos_r == CW'(TABLE_ENTRIES - 1)) begin
            pos_r       <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/sdt_checker.sv =====
// port-level checks for the seen device table
module sdt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input sdt_pkg::sdt_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input sdt_pkg::sdt_out_t out_data
);
  import sdt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.was_hit && out_data.was_evicted))
    else $error("hit and eviction together");

  a_count_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.was_hit |-> out_data.sighting_count == 16'd1)
    else $error("new entry count not one");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted while busy");
endmodule

bind seen_device_table sdt_checker u_sdt_checker (.*);

// ===== bench/tb_top.sv =====
// testbench for the seen device table: scoreboard, drivers and run control
module tb_top;
  import sdt_pkg::*;

  localparam int ENTRIES = 128;

  class sighting_scoreboard;
    logic [47:0]       keys[ENTRIES];
    logic [31:0]       firsts[ENTRIES];
    logic [15:0]       counts[ENTRIES];
    logic signed [7:0] peaks[ENTRIES];
    int                used;
    sdt_out_t          pending[$];
    int                errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function void note_sighting(sdt_in_t s);
      sdt_out_t r;
      int slot;
      bit hit;
      slot = 0;
      hit = 0;
      r = '0;
      for (int i = 0; i < used; i++) begin
        if (keys[i] == s.device_address) begin
          hit = 1;
          slot = i;
          break;
        end
      end
      if (hit) begin
        counts[slot] = counts[slot] + 16'd1;
        if (s.signal_strength > peaks[slot]) peaks[slot] = s.signal_strength;
      end else begin
        if (used < ENTRIES) begin
          slot = used;
          used++;
        end else begin
          slot = 0;
          for (int i = 1; i < ENTRIES; i++)
            if (firsts[i] < firsts[slot]) slot = i;
          r.was_evicted = 1;
        end
        keys[slot] = s.device_address;
        firsts[slot] = s.now_seconds;
        counts[slot] = 16'd1;
        peaks[slot] = s.signal_strength;
      end
      r.was_hit = hit;
      r.entry_slot = slot[6:0];
      r.sighting_count = counts[slot];
      r.peak_strength = peaks[slot];
      r.first_seen_time = firsts[slot];
      r.entries_used = used[7:0];
      pending.push_back(r);
    endfunction

    function void check_result(sdt_out_t got);
      sdt_out_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (got.was_hit !== e.was_hit) report("was_hit", got.was_hit, e.was_hit);
      if (got.was_evicted !== e.was_evicted)
        report("was_evicted", got.was_evicted, e.was_evicted);
      if (got.entry_slot !== e.entry_slot) report("entry_slot", got.entry_slot, e.entry_slot);
      if (got.sighting_count !== e.sighting_count)
        report("sighting_count", got.sighting_count, e.sighting_count);
      if (got.peak_strength !== e.peak_strength)
        report("peak_strength", got.peak_strength, e.peak_strength);
      if (got.first_seen_time !== e.first_seen_time)
        report("first_seen_time", got.first_seen_time, e.first_seen_time);
      if (got.entries_used !== e.entries_used)
        report("entries_used", got.entries_used, e.entries_used);
    endfunction

    function void report(string what, longint got, longint exp);
      errors++;
      $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, exp);
    endfunction
  endclass

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  sdt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 0;
  sdt_out_t out_data;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  int  timestamp = 1000;
  logic [47:0] known[$];

  sighting_scoreboard sb = new();

  seen_device_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_sighting(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // valid stays up after an accept until the next send or drain changes it
  task automatic send(logic [47:0] a, logic signed [7:0] s, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{device_address: a, signal_strength: s, now_seconds: t};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic random_sighting();
    logic [47:0] a;
    logic [31:0] t;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45 && known.size() != 0) a = known[$urandom_range(known.size() - 1)];
    else begin
      a = 48'({$urandom, $urandom});
      known.push_back(a);
    end
    pick = $urandom_range(99);
    if (pick < 10) t = $urandom;
    else if (pick < 25) t = timestamp;
    else begin
      timestamp += $urandom_range(3);
      t = timestamp;
    end
    send(a, 8'($urandom), t);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed corners
    send(48'h0, -8'sd128, 32'h0);
    send(48'hFFFF_FFFF_FFFF, 8'sd127, 32'hFFFF_FFFF);
    send(48'h0, 8'sd127, 32'h5);
    send(48'h0, 8'sd127, 32'h6);
    send(48'h0, -8'sd1, 32'h7);
    send(48'hFFFF_FFFF_FFFF, -8'sd128, 32'h8);
    send(48'hAAAA_AAAA_AAAA, 8'sd85, 32'hAAAA_AAAA);
    send(48'h5555_5555_5555, -8'sd86, 32'h5555_5555);
    known.push_back(48'h0);
    known.push_back(48'hFFFF_FFFF_FFFF);
    // fill the table, then force evictions
    for (int i = 0; i < 124; i++) send(48'h1000 + i, 8'($urandom), 32'd100);
    for (int i = 0; i < 6; i++) send(48'h2000 + i, 8'($urandom), 32'd50);
    drain();
    // phases of idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 75; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 75; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int i = 0; i < 100; i++) random_sighting();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (2000) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) random_sighting();
    join
    drain();
    repeat (300) @(negedge clk);
    if (sb.errors == 0) $display("seen_device_table: match");
    else $display("seen_device_table: mismatch");
    $finish;
  end

  initial begin
    #200000000;
    $display("seen_device_table: mismatch");
    $finish;
  end
endmodule
